/* src/arpc_pkg.sv */
// Package for the ARP cache: op and result codes, field widths, reset values.
// No dependencies; imported by arp_cache_with_retry and its testbench.
package arpc_pkg;
    localparam int IP_W    = 32;
    localparam int MAC_W   = 48;
    localparam int IFACE_W = 4;
    localparam int OP_W    = 3;
    localparam int KIND_W  = 3;
    localparam int TMO_W   = 16;
    localparam int SEND_W  = 8;
    localparam int CFG_W   = 16;
    localparam int CFGA_W  = 1;

    localparam int DEF_ENTRY_DEPTH = 16;
    localparam int DEF_REQ_DEPTH   = 16;
    localparam int DEF_IFACE_COUNT = 16;

    localparam logic [TMO_W-1:0]  TMO_RST  = 16'd30;
    localparam logic [SEND_W-1:0] SEND_RST = 8'd5;

    localparam logic [CFGA_W-1:0] REG_TIMEOUT   = 1'd0;
    localparam logic [CFGA_W-1:0] REG_MAX_SENDS = 1'd1;

    localparam logic [OP_W-1:0] OP_LOOKUP = 3'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
    localparam logic [OP_W-1:0] OP_QUEUE  = 3'd2;
    localparam logic [OP_W-1:0] OP_REMOVE = 3'd3;
    localparam logic [OP_W-1:0] OP_TICK   = 3'd4;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd5;

    localparam logic [KIND_W-1:0] K_LOOKUP = 3'd0;
    localparam logic [KIND_W-1:0] K_INSERT = 3'd1;
    localparam logic [KIND_W-1:0] K_QUEUE  = 3'd2;
    localparam logic [KIND_W-1:0] K_REMOVE = 3'd3;
    localparam logic [KIND_W-1:0] K_SEND   = 3'd4;
    localparam logic [KIND_W-1:0] K_TICK   = 3'd5;
    localparam logic [KIND_W-1:0] K_CLEAR  = 3'd6;
endpackage

/* src/arp_cache_with_retry.sv */
// ARP cache with pending-request retry. Cache entries (address, MAC, age, live)
// and pending requests sit in two RAM-backed tables of ENTRY_DEPTH and REQ_DEPTH
// slots. Lookup walks the cache table, queue and remove the request table, and
// insert and tick walk both, one slot per cycle through the RAM read port (read,
// compare, write back); a tick walk holds on each send beat until the output
// register is free. Clear only resets the live bits.
// One item is in work at a time; the result register decouples the two sides,
// so the next item is accepted as soon as the sequencer is idle, even while the
// last result beat still waits. Uses arpc_pkg and arpc_ram.
module arp_cache_with_retry
    import arpc_pkg::*;
#(
    parameter int ENTRY_DEPTH = DEF_ENTRY_DEPTH,
    parameter int REQ_DEPTH   = DEF_REQ_DEPTH,
    parameter int IFACE_COUNT = DEF_IFACE_COUNT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CFGA_W-1:0]  i_cfg_idx,
    input  logic [CFG_W-1:0]   i_cfg_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [OP_W-1:0]    i_op,
    input  logic [IP_W-1:0]    i_ip,
    input  logic [MAC_W-1:0]   i_mac,
    input  logic [IFACE_W-1:0] i_iface,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [KIND_W-1:0]  o_kind,
    output logic               o_hit,
    output logic [MAC_W-1:0]   o_found_mac,
    output logic [IP_W-1:0]    o_target_ip,
    output logic [IFACE_W-1:0] o_send_iface,
    output logic               o_full_res,
    output logic               o_last
);
    localparam int EA_W = $clog2(ENTRY_DEPTH);
    localparam int RA_W = $clog2(REQ_DEPTH);
    localparam int EC_W = $clog2(ENTRY_DEPTH + 1);
    localparam int RC_W = $clog2(REQ_DEPTH + 1);
    localparam int EW_W = IP_W + MAC_W + TMO_W;
    localparam int RW_W = IP_W + IFACE_W + SEND_W;
    localparam logic [IFACE_W-1:0] IFACE_MAX = IFACE_W'(IFACE_COUNT - 1);

    // sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_ESCAN = 4'd1;  // cache walk (lookup/insert/tick)
    localparam logic [3:0] S_RSCAN = 4'd2;  // request walk (insert/queue/remove/tick)
    localparam logic [3:0] S_FIN   = 4'd3;  // act on scan results
    localparam logic [3:0] S_SEND  = 4'd4;  // tick send beat waiting
    localparam logic [3:0] S_OUT   = 4'd5;  // final beat waiting

    logic [3:0] r_state, n_state;
    logic [TMO_W-1:0]  r_tmo;
    logic [SEND_W-1:0] r_maxs;

    // latched item
    logic [OP_W-1:0]    r_op;
    logic [IP_W-1:0]    r_ip;
    logic [MAC_W-1:0]   r_mac;
    logic [IFACE_W-1:0] r_iface;

    logic [ENTRY_DEPTH-1:0] r_elive;
    logic [REQ_DEPTH-1:0]   r_rlive;

    // scan counters: issue index and a check index that trails it by one register
    logic [EC_W-1:0] r_ecnt;
    logic [RC_W-1:0] r_rcnt;
    logic            r_chk;
    logic [EA_W-1:0] r_eidx;
    logic [RA_W-1:0] r_ridx;

    // scan results
    logic            r_ematch, r_efree, r_pmatch, r_pfree;
    logic [EA_W-1:0] r_emslot, r_efslot;
    logic [RA_W-1:0] r_pmslot, r_pfslot;
    logic [MAC_W-1:0] r_fmac;

    // request slot held for a send beat and its write-back
    logic [IP_W-1:0]    r_sip;
    logic [IFACE_W-1:0] r_sif;
    logic [SEND_W-1:0]  r_ssnd;

    // output register
    logic               r_ov;
    logic [KIND_W-1:0]  r_kind;
    logic               r_hit, r_full, r_last;
    logic [MAC_W-1:0]   r_omac;
    logic [IP_W-1:0]    r_oip;
    logic [IFACE_W-1:0] r_oif;

    // RAM ports
    logic            e_we, r_we;
    logic [EA_W-1:0] e_wa, e_ra;
    logic [RA_W-1:0] q_wa, q_ra;
    logic [EW_W-1:0] e_wd, e_rd;
    logic [RW_W-1:0] q_wd, q_rd;

    arpc_ram #(.WIDTH(EW_W), .DEPTH(ENTRY_DEPTH)) u_eram (
        .i_clk(i_clk), .i_we(e_we), .i_waddr(e_wa), .i_wdata(e_wd),
        .i_raddr(e_ra), .o_rdata(e_rd));
    arpc_ram #(.WIDTH(RW_W), .DEPTH(REQ_DEPTH)) u_rram (
        .i_clk(i_clk), .i_we(r_we), .i_waddr(q_wa), .i_wdata(q_wd),
        .i_raddr(q_ra), .o_rdata(q_rd));

    logic [IP_W-1:0]   e_ip, q_ip;
    logic [MAC_W-1:0]  e_mac;
    logic [TMO_W-1:0]  e_age, e_age1;
    logic [IFACE_W-1:0] q_if;
    logic [SEND_W-1:0] q_snd;
    assign {e_ip, e_mac, e_age} = e_rd;
    assign {q_ip, q_if, q_snd}  = q_rd;
    assign e_age1 = (e_age == '1) ? e_age : e_age + 1'b1;

    logic accept, out_free, is_tick, e_last_iss, r_last_iss;
    assign accept   = i_valid && !o_stall;
    assign out_free = !r_ov || !i_stall;
    assign o_stall  = (r_state != S_IDLE);
    assign is_tick  = (r_op == OP_TICK);
    assign e_last_iss = (r_ecnt == EC_W'(ENTRY_DEPTH));
    assign r_last_iss = (r_rcnt == RC_W'(REQ_DEPTH));

    assign e_ra = r_ecnt[EA_W-1:0];
    assign q_ra = r_rcnt[RA_W-1:0];

    // tick-walk pending send: in S_SEND the checked slot data is held
    logic send_fire;

    always_comb begin
        n_state = r_state;
        e_we = 1'b0; e_wa = r_eidx; e_wd = {e_ip, e_mac, e_age1};
        r_we = 1'b0; q_wa = r_ridx; q_wd = {r_sip, r_sif, r_ssnd};
        send_fire = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_op inside {OP_LOOKUP, OP_INSERT, OP_TICK}) begin
                        n_state = S_ESCAN;
                    end else if (i_op inside {OP_QUEUE, OP_REMOVE}) begin
                        n_state = S_RSCAN;
                    end else if (i_op == OP_CLEAR) begin
                        n_state = S_OUT;
                    end
                end
            end
            S_ESCAN: begin
                if (r_chk && is_tick && r_elive[r_eidx]) begin
                    e_we = 1'b1;
                end
                if (r_chk && r_eidx == EA_W'(ENTRY_DEPTH - 1)) begin
                    n_state = (r_op == OP_LOOKUP) ? S_FIN : S_RSCAN;
                end
            end
            S_RSCAN: begin
                if (r_chk && is_tick && r_rlive[r_ridx] && q_snd < r_maxs) begin
                    send_fire = 1'b1;
                    n_state = S_SEND;
                end else if (r_chk && r_ridx == RA_W'(REQ_DEPTH - 1)) begin
                    n_state = S_FIN;
                end
            end
            S_SEND: begin
                if (out_free) begin
                    r_we = 1'b1;
                    n_state = (r_ridx == RA_W'(REQ_DEPTH - 1)) ? S_FIN : S_RSCAN;
                end
            end
            S_FIN: begin
                if (r_op == OP_INSERT && (r_ematch || r_efree)) begin
                    e_we = 1'b1;
                    e_wa = r_ematch ? r_emslot : r_efslot;
                    e_wd = {r_ip, r_mac, {TMO_W{1'b0}}};
                end
                if (r_op == OP_QUEUE && !r_pmatch && r_pfree) begin
                    r_we = 1'b1;
                    q_wa = r_pfslot;
                    q_wd = {r_ip, (r_iface > IFACE_MAX) ? IFACE_MAX : r_iface,
                            {SEND_W{1'b0}}};
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_tmo   <= TMO_RST;
            r_maxs  <= SEND_RST;
            r_elive <= '0;
            r_rlive <= '0;
            r_ov    <= 1'b0;
            r_chk   <= 1'b0;
            r_ecnt  <= '0;
            r_rcnt  <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_TIMEOUT:   r_tmo  <= i_cfg_data;
                    REG_MAX_SENDS: r_maxs <= i_cfg_data[SEND_W-1:0];
                    default: ;
                endcase
            end
            // beat taken; the states that load a new beat set it themselves
            if (r_ov && !i_stall && r_state != S_SEND && r_state != S_OUT) begin
                r_ov <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_op <= i_op; r_ip <= i_ip; r_mac <= i_mac; r_iface <= i_iface;
                        r_ematch <= 1'b0; r_efree <= 1'b0;
                        r_pmatch <= 1'b0; r_pfree <= 1'b0;
                        r_fmac <= '0;
                        r_ecnt <= '0; r_rcnt <= '0; r_chk <= 1'b0;
                        if (i_op == OP_CLEAR) begin
                            r_elive <= '0; r_rlive <= '0;
                        end
                    end
                end
                S_ESCAN: begin
                    if (!e_last_iss) r_ecnt <= r_ecnt + 1'b1;
                    r_chk  <= !e_last_iss;
                    r_eidx <= r_ecnt[EA_W-1:0];
                    if (r_chk) begin
                        if (is_tick) begin
                            if (r_elive[r_eidx] && e_age1 > r_tmo) r_elive[r_eidx] <= 1'b0;
                        end else if (r_elive[r_eidx] && e_ip == r_ip && !r_ematch) begin
                            r_ematch <= 1'b1; r_emslot <= r_eidx; r_fmac <= e_mac;
                        end else if (!r_elive[r_eidx] && !r_efree) begin
                            r_efree <= 1'b1; r_efslot <= r_eidx;
                        end
                    end
                end
                S_RSCAN: begin
                    if (!send_fire) begin
                        if (!r_last_iss) r_rcnt <= r_rcnt + 1'b1;
                        r_chk  <= !r_last_iss;
                        r_ridx <= r_rcnt[RA_W-1:0];
                    end
                    if (r_chk) begin
                        if (is_tick) begin
                            if (r_rlive[r_ridx] && q_snd >= r_maxs) r_rlive[r_ridx] <= 1'b0;
                        end else if (r_rlive[r_ridx] && q_ip == r_ip && !r_pmatch) begin
                            r_pmatch <= 1'b1; r_pmslot <= r_ridx;
                        end else if (!r_rlive[r_ridx] && !r_pfree) begin
                            r_pfree <= 1'b1; r_pfslot <= r_ridx;
                        end
                    end
                    if (send_fire) begin
                        // hold the slot until its beat is loaded and written back
                        r_sip <= q_ip; r_sif <= q_if; r_ssnd <= q_snd + 1'b1;
                        r_chk <= 1'b0;
                    end
                end
                S_SEND: begin
                    if (out_free) begin
                        r_ov <= 1'b1; r_kind <= K_SEND; r_hit <= 1'b0;
                        r_full <= 1'b0; r_last <= 1'b0; r_omac <= '0;
                        r_oip <= r_sip; r_oif <= r_sif;
                        // re-read the next slot; r_rcnt already points at it
                        r_chk  <= (r_ridx != RA_W'(REQ_DEPTH - 1));
                        r_ridx <= r_rcnt[RA_W-1:0];
                        if (!r_last_iss) r_rcnt <= r_rcnt + 1'b1;
                    end
                end
                S_FIN: begin
                    if (r_op == OP_INSERT && (r_ematch || r_efree)) begin
                        r_elive[r_ematch ? r_emslot : r_efslot] <= 1'b1;
                    end
                    if (r_op == OP_QUEUE && !r_pmatch && r_pfree) r_rlive[r_pfslot] <= 1'b1;
                    if (r_op == OP_REMOVE && r_pmatch) r_rlive[r_pmslot] <= 1'b0;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_ov <= 1'b1; r_last <= 1'b1;
                        r_oip <= '0; r_oif <= '0;
                        r_omac <= (r_op == OP_LOOKUP) ? r_fmac : '0;
                        r_hit <= (r_op == OP_LOOKUP) ? r_ematch :
                                 (r_op == OP_INSERT) ? r_pmatch : 1'b0;
                        r_full <= (r_op == OP_INSERT) ? !(r_ematch || r_efree) :
                                  (r_op == OP_QUEUE) ? (!r_pmatch && !r_pfree) : 1'b0;
                        case (r_op)
                            OP_LOOKUP: r_kind <= K_LOOKUP;
                            OP_INSERT: r_kind <= K_INSERT;
                            OP_QUEUE:  r_kind <= K_QUEUE;
                            OP_REMOVE: r_kind <= K_REMOVE;
                            OP_TICK:   r_kind <= K_TICK;
                            default:   r_kind <= K_CLEAR;
                        endcase
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_valid      = r_ov;
    assign o_kind       = r_kind;
    assign o_hit        = r_hit;
    assign o_found_mac  = r_omac;
    assign o_target_ip  = r_oip;
    assign o_send_iface = r_oif;
    assign o_full_res   = r_full;
    assign o_last       = r_last;
endmodule

/* src/arpc_ram.sv */
// Generic single-port-write, one-read RAM with registered read data.
// No dependencies.
module arpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

/* test/arp_cache_with_retry_tb.sv */
// Testbench for arp_cache_with_retry: directed and random op beats checked
// against a behavioral cache/request-table predictor. Depends on arpc_pkg.
module arp_cache_with_retry_tb;
    import arpc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NE = DEF_ENTRY_DEPTH;
    localparam int NR = DEF_REQ_DEPTH;
    localparam int NI = DEF_IFACE_COUNT;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic               hit;
        logic [MAC_W-1:0]   found_mac;
        logic [IP_W-1:0]    target_ip;
        logic [IFACE_W-1:0] send_iface;
        logic               full_res;
        logic               last;
    } arp_res_t;

    // Scoreboard: mirror of both tables plus the queue of expected results
    class arp_scoreboard;
        logic [TMO_W-1:0]   timeout;
        logic [SEND_W-1:0]  send_limit;
        logic [IP_W-1:0]    c_ip   [NE];
        logic [MAC_W-1:0]   c_mac  [NE];
        logic               c_live [NE];
        logic [TMO_W-1:0]   c_age  [NE];
        logic [IP_W-1:0]    r_ip   [NR];
        logic [IFACE_W-1:0] r_port [NR];
        logic [SEND_W-1:0]  r_sent [NR];
        logic               r_live [NR];
        arp_res_t           pending_res[$];
        int                 errors;

        function new();
            timeout = TMO_RST;
            send_limit = SEND_RST;
            errors = 0;
            for (int i = 0; i < NE; i++) begin
                c_live[i] = 0; c_ip[i] = 0; c_mac[i] = 0; c_age[i] = 0;
            end
            for (int i = 0; i < NR; i++) begin
                r_live[i] = 0; r_ip[i] = 0; r_port[i] = 0; r_sent[i] = 0;
            end
        endfunction

        function void write_reg(logic [CFGA_W-1:0] idx, logic [CFG_W-1:0] d);
            if (idx == REG_TIMEOUT) timeout = d;
            else send_limit = d[SEND_W-1:0];
        endfunction

        function int find_req(logic [IP_W-1:0] ip);
            for (int i = 0; i < NR; i++)
                if (r_live[i] && r_ip[i] == ip) return i;
            return -1;
        endfunction

        function void push(logic [KIND_W-1:0] k, logic h, logic [MAC_W-1:0] m,
                           logic [IP_W-1:0] t, logic [IFACE_W-1:0] p, logic f,
                           logic l);
            arp_res_t r;
            r = '{k, h, m, t, p, f, l};
            pending_res.insert(pending_res.size(), r);
        endfunction

        // note an accepted op beat and predict its results
        function void note_op(logic [OP_W-1:0] op, logic [IP_W-1:0] ip,
                              logic [MAC_W-1:0] mac, logic [IFACE_W-1:0] ifc);
            int slot;
            bit done;
            done = 0;
            slot = -1;
            case (op)
                OP_LOOKUP: begin
                    for (int i = 0; i < NE && !done; i++)
                        if (c_live[i] && c_ip[i] == ip) begin
                            push(K_LOOKUP, 1, c_mac[i], 0, 0, 0, 1);
                            done = 1;
                        end
                    if (!done) push(K_LOOKUP, 0, 0, 0, 0, 0, 1);
                end
                OP_INSERT: begin
                    for (int i = 0; i < NE && slot < 0; i++)
                        if (c_live[i] && c_ip[i] == ip) slot = i;
                    for (int i = 0; i < NE && slot < 0; i++)
                        if (!c_live[i]) slot = i;
                    if (slot >= 0) begin
                        c_ip[slot] = ip; c_mac[slot] = mac;
                        c_age[slot] = 0; c_live[slot] = 1;
                    end
                    push(K_INSERT, find_req(ip) >= 0, 0, 0, 0, slot < 0, 1);
                end
                OP_QUEUE: begin
                    if (find_req(ip) >= 0) push(K_QUEUE, 0, 0, 0, 0, 0, 1);
                    else begin
                        for (int i = 0; i < NR && slot < 0; i++)
                            if (!r_live[i]) slot = i;
                        if (slot >= 0) begin
                            r_ip[slot] = ip;
                            r_port[slot] = (ifc >= NI) ? IFACE_W'(NI - 1) : ifc;
                            r_sent[slot] = 0; r_live[slot] = 1;
                        end
                        push(K_QUEUE, 0, 0, 0, 0, slot < 0, 1);
                    end
                end
                OP_REMOVE: begin
                    slot = find_req(ip);
                    if (slot >= 0) r_live[slot] = 0;
                    push(K_REMOVE, 0, 0, 0, 0, 0, 1);
                end
                OP_TICK: begin
                    for (int i = 0; i < NE; i++)
                        if (c_live[i]) begin
                            if (c_age[i] != 16'hFFFF) c_age[i]++;
                            if (c_age[i] > timeout) c_live[i] = 0;
                        end
                    for (int i = 0; i < NR; i++)
                        if (r_live[i]) begin
                            if (r_sent[i] >= send_limit) r_live[i] = 0;
                            else begin
                                push(K_SEND, 0, 0, r_ip[i], r_port[i], 0, 0);
                                r_sent[i]++;
                            end
                        end
                    push(K_TICK, 0, 0, 0, 0, 0, 1);
                end
                OP_CLEAR: begin
                    for (int i = 0; i < NE; i++) c_live[i] = 0;
                    for (int i = 0; i < NR; i++) r_live[i] = 0;
                    push(K_CLEAR, 0, 0, 0, 0, 0, 1);
                end
                default: ;
            endcase
        endfunction

        function void check_res(arp_res_t got);
            arp_res_t exp_r;
            if (pending_res.size() == 0) begin
                $display("%0t: unexpected result %p", $realtime, got);
                errors++;
                return;
            end
            exp_r = pending_res.pop_front();
            if (got.kind != exp_r.kind || got.hit != exp_r.hit
                || got.found_mac != exp_r.found_mac
                || got.target_ip != exp_r.target_ip
                || got.send_iface != exp_r.send_iface
                || got.full_res != exp_r.full_res || got.last != exp_r.last) begin
                $display("%0t: mismatch expected %p actual %p", $realtime, exp_r, got);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk, i_rst_n, i_cfg_we, i_valid, i_stall;
    logic [CFGA_W-1:0]  i_cfg_idx;
    logic [CFG_W-1:0]   i_cfg_data;
    logic [OP_W-1:0]    i_op;
    logic [IP_W-1:0]    i_ip;
    logic [MAC_W-1:0]   i_mac;
    logic [IFACE_W-1:0] i_iface;
    logic               o_stall, o_valid, o_hit, o_full_res, o_last;
    logic [KIND_W-1:0]  o_kind;
    logic [MAC_W-1:0]   o_found_mac;
    logic [IP_W-1:0]    o_target_ip;
    logic [IFACE_W-1:0] o_send_iface;

    arp_cache_with_retry u_top (.*);

    arp_scoreboard sb;
    int send_idle_pct, recv_idle_pct;
    logic [IP_W-1:0] ip_pool[8];

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("Verification failed");
        $finish;
    end

    // receiver: random stall at the falling edge, check at the rising edge
    always @(negedge i_clk)
        i_stall <= ($urandom_range(99) < recv_idle_pct);

    always @(posedge i_clk)
        if (i_rst_n && o_valid && !i_stall)
            sb.check_res('{o_kind, o_hit, o_found_mac, o_target_ip, o_send_iface,
                           o_full_res, o_last});

    // valid drops only on idle cycles, so beats can follow back to back
    task automatic send_op(logic [OP_W-1:0] op, logic [IP_W-1:0] ip,
                           logic [MAC_W-1:0] mac, logic [IFACE_W-1:0] ifc);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 0;
            @(negedge i_clk);
        end
        i_valid <= 1; i_op <= op; i_ip <= ip; i_mac <= mac; i_iface <= ifc;
        do @(posedge i_clk); while (o_stall);
        sb.note_op(op, ip, mac, ifc);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 0;
        while (sb.pending_res.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic write_cfg(logic [CFGA_W-1:0] idx, logic [CFG_W-1:0] d);
        drain();
        i_cfg_we <= 1; i_cfg_idx <= idx; i_cfg_data <= d;
        @(posedge i_clk);
        sb.write_reg(idx, d);
        @(negedge i_clk);
        i_cfg_we <= 0;
    endtask

    function automatic logic [IP_W-1:0] pick_ip();
        return ($urandom_range(9) < 8) ? ip_pool[$urandom_range(7)] : $urandom;
    endfunction

    // random phase: mostly a small address pool so ops hit each other
    task automatic random_ops(int n);
        int r;
        logic [OP_W-1:0] op;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(99);
            if (r < 25) op = OP_LOOKUP;
            else if (r < 50) op = OP_INSERT;
            else if (r < 68) op = OP_QUEUE;
            else if (r < 78) op = OP_REMOVE;
            else if (r < 93) op = OP_TICK;
            else if (r < 96) op = OP_CLEAR;
            else op = OP_W'($urandom_range(7, 6));
            send_op(op, pick_ip(), MAC_W'({$urandom, $urandom}), IFACE_W'($urandom));
        end
    endtask

    initial begin
        sb = new();
        i_rst_n = 0; i_cfg_we = 0; i_cfg_idx = REG_TIMEOUT; i_cfg_data = 0;
        i_valid = 0; i_op = OP_LOOKUP; i_ip = 0; i_mac = 0;
        i_iface = 0;
        send_idle_pct = 38; recv_idle_pct = 70;
        for (int i = 0; i < 8; i++) ip_pool[i] = $urandom;
        ip_pool[0] = '0; ip_pool[1] = '1;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // directed: extremes, every op, full tables, duplicates, ignored ops
        send_op(OP_LOOKUP, '0, '0, '0);
        send_op(OP_QUEUE, '1, '0, '1);
        send_op(OP_QUEUE, '1, '0, 4'd3);
        send_op(OP_INSERT, '1, '1, '0);
        send_op(OP_INSERT, '1, 48'h1234_5678_9abc, '0);
        send_op(OP_LOOKUP, '1, '0, '0);
        send_op(OP_INSERT, '0, '0, '0);
        send_op(OP_LOOKUP, '0, '1, '1);
        send_op(OP_REMOVE, 32'h5, '0, '0);
        send_op(OP_REMOVE, '1, '0, '0);
        send_op(3'd6, '0, '0, '0);
        send_op(3'd7, '1, '1, '1);
        for (int i = 0; i < NE + 1; i++)
            send_op(OP_INSERT, 32'h100 + i, MAC_W'($urandom), '0);
        for (int i = 0; i < NR + 1; i++)
            send_op(OP_QUEUE, 32'h200 + i, '0, IFACE_W'(i));
        send_op(OP_TICK, '0, '0, '0);
        send_op(OP_CLEAR, '0, '0, '0);

        write_cfg(REG_TIMEOUT, 16'd0);
        write_cfg(REG_MAX_SENDS, 16'd0);
        send_op(OP_INSERT, 32'h7, '1, '0);
        send_op(OP_QUEUE, 32'h7, '0, 4'd9);
        send_op(OP_TICK, '0, '0, '0);
        send_op(OP_LOOKUP, 32'h7, '0, '0);

        write_cfg(REG_TIMEOUT, 16'd3);
        write_cfg(REG_MAX_SENDS, 16'd2);
        random_ops(150);
        send_idle_pct = 70; recv_idle_pct = 38;
        write_cfg(REG_TIMEOUT, 16'hFFFF);
        write_cfg(REG_MAX_SENDS, 16'hFF);
        random_ops(150);
        send_idle_pct = 0; recv_idle_pct = 0;
        write_cfg(REG_TIMEOUT, 16'd1);
        write_cfg(REG_MAX_SENDS, 16'd1);
        random_ops(80);
        write_cfg(REG_TIMEOUT, 16'd30);
        write_cfg(REG_MAX_SENDS, 16'd5);
        random_ops(40);
        drain();

        if (sb.errors == 0 && sb.pending_res.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
